FILE: sv/fcd_pkg.sv
// Shared types and constants for the frame change detector.
`timescale 1ns / 1ps
`default_nettype none

package fcd_pkg;

  localparam int MAX_PIXELS = 65536;

  localparam int PIX_W     = 24;
  localparam int SRC_W     = 16;
  localparam int SIDE_W    = 13;
  localparam int COUNT_W   = 17;
  localparam int CFG_IDX_W = 1;

  // Stream tdata widths, padded to whole bytes, and the tuser width
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT     = '1;
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(32);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANGE_THRESHOLD = 1'b0,
    REG_WHOLE_SCREEN     = 1'b1
  } cfg_reg_t;

  // Pixel in flight between the store read and the compare
  typedef struct packed {
    logic              cmp_en;
    logic              last;
    logic              switched;
    logic              size_same;
    logic              too_large;
    logic [PIX_W-1:0]  pixel;
    logic [SRC_W-1:0]  source;
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
  } stage_t;

  // Frame verdict handed back to the reference state
  typedef struct packed {
    logic done;
    logic changed;
  } judge_t;

endpackage

`default_nettype wire

FILE: sv/frame_change_detector.sv
// Frame change detector top level: input stage, reference state, configuration.
//
// Pixels enter on the s_ stream in raster order, one per transfer; s_tlast
// marks the last pixel of a frame. Each pixel that fits the store is written
// to the spare bank of a two-bank frame store and, if the frame size matches
// the reference, compared with the same position of the reference bank. On
// the last pixel the frame is judged and one result leaves on the m_ stream:
// changed flag, differing pixel count, source switch and oversize flags. A
// changed frame swaps banks and becomes the new reference.
// Throughput is one pixel per cycle within a frame. After the last pixel of
// a frame the input holds s_tready low until the verdict, which needs the
// store read of that pixel, settles the bank swap and the reference size.
// The last pixel waits in the stage register for the verdict, which is then
// registered in the output register. If the receiver stalls, the result
// waits there while the next frame streams in; only the next frame's last
// pixel waits. Reset clears the reference (the first frame always counts as
// changed), the counters and the registers to their defaults; the store is
// not cleared. Configuration writes on cfg_ are taken every cycle.
`timescale 1ns / 1ps
`default_nettype none

module frame_change_detector #(
  parameter int MAX_PIXELS = fcd_pkg::MAX_PIXELS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // tdata: pixel_rgb[23:0], frame_width[36:24], frame_height[49:37], zero pad
  input  wire logic [fcd_pkg::IN_TDATA_W-1:0]      s_tdata,
  // tuser: source_id[15:0]
  input  wire logic [fcd_pkg::SRC_W-1:0]           s_tuser,
  input  wire logic                                s_tlast,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // tdata: differing_pixels[16:0], zero pad
  output logic [fcd_pkg::OUT_TDATA_W-1:0]          m_tdata,
  // tuser: frame_changed[0], source_switched[1], frame_too_large[2]
  output logic [fcd_pkg::OUT_TUSER_W-1:0]          m_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [fcd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [fcd_pkg::COUNT_W-1:0]         cfg_data
);

  localparam int POS_AW = $clog2(MAX_PIXELS);
  localparam int POS_W  = POS_AW + 1;

  logic [fcd_pkg::COUNT_W-1:0] threshold;
  logic                        whole_screen;

  logic                        ref_bank;
  logic                        ref_valid;
  logic [fcd_pkg::SIDE_W-1:0]  ref_width;
  logic [fcd_pkg::SIDE_W-1:0]  ref_height;
  logic [fcd_pkg::SRC_W-1:0]   last_source;
  logic [POS_W-1:0]            pixel_position;

  logic                        s1_valid;
  fcd_pkg::stage_t             stage;
  fcd_pkg::stage_t             stage_next;
  fcd_pkg::judge_t             jd;

  logic                        accept;
  logic                        too_large;
  logic [POS_W-1:0]            wr_addr;
  logic [POS_W-1:0]            rd_addr;
  logic [fcd_pkg::PIX_W-1:0]   rd_data;

  assign cfg_ready = 1'b1;
  assign s_tready  = !(s1_valid && stage.last);
  assign accept    = s_tvalid && s_tready;
  assign too_large = (pixel_position == POS_W'(MAX_PIXELS));
  assign wr_addr   = {~ref_bank, pixel_position[POS_AW-1:0]};
  assign rd_addr   = {ref_bank, pixel_position[POS_AW-1:0]};

  always_comb begin
    stage_next.pixel     = s_tdata[23:0];
    stage_next.width     = s_tdata[36:24];
    stage_next.height    = s_tdata[49:37];
    stage_next.source    = s_tuser;
    stage_next.last      = s_tlast;
    stage_next.too_large = too_large;
    stage_next.size_same = ref_valid && (stage_next.width == ref_width) &&
                           (stage_next.height == ref_height);
    stage_next.cmp_en    = stage_next.size_same && !too_large;
    stage_next.switched  = !whole_screen && (s_tuser != last_source);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= fcd_pkg::THRESHOLD_RESET;
      whole_screen <= 1'b0;
    end else if (cfg_valid) begin
      unique case (fcd_pkg::cfg_reg_t'(cfg_index))
        fcd_pkg::REG_CHANGE_THRESHOLD: threshold    <= cfg_data;
        fcd_pkg::REG_WHOLE_SCREEN:     whole_screen <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Position saturates once the store is full
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        pixel_position <= '0;
      end else if (!too_large) begin
        pixel_position <= pixel_position + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (!stage.last || jd.done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

  // Swap banks and take the new reference on a changed frame
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_bank    <= 1'b0;
      ref_valid   <= 1'b0;
      ref_width   <= '0;
      ref_height  <= '0;
      last_source <= '0;
    end else if (jd.done && jd.changed) begin
      ref_bank   <= ~ref_bank;
      ref_valid  <= 1'b1;
      ref_width  <= stage.width;
      ref_height <= stage.height;
      if (stage.switched) begin
        last_source <= stage.source;
      end
    end
  end

  fcd_store #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && !too_large),
    .wr_addr (wr_addr),
    .wr_data (stage_next.pixel),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fcd_judge u_judge (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .stage     (stage),
    .rd_data   (rd_data),
    .threshold (threshold),
    .jd        (jd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

FILE: sv/fcd_store.sv
// Two-bank frame store: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none

module fcd_store #(
  parameter int MAX_PIXELS = fcd_pkg::MAX_PIXELS
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [$clog2(MAX_PIXELS):0]          wr_addr,
  input  wire logic [fcd_pkg::PIX_W-1:0]            wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [$clog2(MAX_PIXELS):0]          rd_addr,
  output logic      [fcd_pkg::PIX_W-1:0]            rd_data
);

  localparam int ADDR_W = $clog2(MAX_PIXELS) + 1;
  localparam int DEPTH  = 2 ** ADDR_W;

  logic [fcd_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/fcd_judge.sv
// Difference counter, frame verdict and result register.
`timescale 1ns / 1ps
`default_nettype none

module fcd_judge (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s1_valid,
  input  wire fcd_pkg::stage_t                   stage,
  input  wire logic [fcd_pkg::PIX_W-1:0]         rd_data,
  input  wire logic [fcd_pkg::COUNT_W-1:0]       threshold,
  output fcd_pkg::judge_t                        jd,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [fcd_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic [fcd_pkg::OUT_TUSER_W-1:0]        m_tuser
);

  logic [fcd_pkg::COUNT_W-1:0] count;
  logic [fcd_pkg::COUNT_W-1:0] count_now;
  logic                        inc;
  logic [fcd_pkg::COUNT_W-1:0] diff;
  logic                        changed_q;
  logic                        switched_q;
  logic                        too_large_q;

  always_comb begin
    inc = stage.cmp_en && (stage.pixel != rd_data) && (count != fcd_pkg::COUNT_LIMIT);
    count_now  = count + fcd_pkg::COUNT_W'(inc);
    jd.done    = s1_valid && stage.last && (!m_tvalid || m_tready);
    jd.changed = stage.switched || !stage.size_same || (count_now >= threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (jd.done) begin
      count <= '0;
    end else if (s1_valid && !stage.last) begin
      count <= count_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (jd.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (jd.done) begin
      diff        <= count_now;
      changed_q   <= jd.changed;
      switched_q  <= stage.switched;
      too_large_q <= stage.too_large;
    end
  end

  assign m_tdata = {{(fcd_pkg::OUT_TDATA_W - fcd_pkg::COUNT_W){1'b0}}, diff};
  assign m_tuser = {too_large_q, switched_q, changed_q};

endmodule

`default_nettype wire

FILE: verif/fcd_checker.sv
// Checker for the frame change detector: predicts each frame verdict and compares the result stream.
`timescale 1ns / 1ps

module fcd_checker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // tdata: pixel_rgb[23:0], frame_width[36:24], frame_height[49:37], zero pad
  input  wire logic [fcd_pkg::IN_TDATA_W-1:0]     s_tdata,
  // tuser: source_id[15:0]
  input  wire logic [fcd_pkg::SRC_W-1:0]          s_tuser,
  input  wire logic                               s_tlast,
  input  wire logic                               s_tvalid,
  input  wire logic                               s_tready,
  // tdata: differing_pixels[16:0], zero pad
  input  wire logic [fcd_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // tuser: frame_changed[0], source_switched[1], frame_too_large[2]
  input  wire logic [fcd_pkg::OUT_TUSER_W-1:0]    m_tuser,
  input  wire logic                               m_tvalid,
  input  wire logic                               m_tready,
  input  wire logic                               cfg_valid,
  input  wire logic                               cfg_ready,
  input  wire logic [fcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fcd_pkg::COUNT_W-1:0]        cfg_data,
  output int                                      verdicts_due,
  output int                                      fail_count
);

  typedef struct packed {
    logic                         changed;
    logic [fcd_pkg::COUNT_W-1:0]  diff_count;
    logic                         switched;
    logic                         oversize;
  } verdict_t;

  verdict_t verdict_q[$];
  int       mismatches = 0;

  // Two banks of the frame store; the reference bank is ref_sel
  bit [fcd_pkg::PIX_W-1:0]   bank_mem [0:1][0:fcd_pkg::MAX_PIXELS-1];
  bit                        ref_sel;
  bit                        have_ref;
  bit [fcd_pkg::SIDE_W-1:0]  ref_w;
  bit [fcd_pkg::SIDE_W-1:0]  ref_h;
  bit [fcd_pkg::SRC_W-1:0]   prev_src;
  bit [fcd_pkg::COUNT_W-1:0] diff_acc;
  int unsigned               pos;
  bit [fcd_pkg::COUNT_W-1:0] threshold;
  bit                        whole_screen;

  assign fail_count = mismatches;

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  task automatic absorb_pixel(input logic [fcd_pkg::IN_TDATA_W-1:0] data,
                              input logic [fcd_pkg::SRC_W-1:0] src, input logic last);
    logic [fcd_pkg::PIX_W-1:0]  pix;
    logic [fcd_pkg::SIDE_W-1:0] w;
    logic [fcd_pkg::SIDE_W-1:0] h;
    logic                       same_size;
    logic                       oversize;
    logic                       switched;
    logic                       changed;
    verdict_t                   v;
    pix = data[fcd_pkg::PIX_W-1:0];
    w = data[fcd_pkg::PIX_W +: fcd_pkg::SIDE_W];
    h = data[fcd_pkg::PIX_W + fcd_pkg::SIDE_W +: fcd_pkg::SIDE_W];
    same_size = have_ref && w == ref_w && h == ref_h;
    oversize = pos >= fcd_pkg::MAX_PIXELS;
    // pixels past the store are neither compared nor kept
    if (!oversize) begin
      if (same_size && bank_mem[ref_sel][pos] != pix && diff_acc != fcd_pkg::COUNT_LIMIT)
        diff_acc++;
      bank_mem[!ref_sel][pos] = pix;
      pos++;
    end
    if (last) begin
      switched = !whole_screen && src != prev_src;
      changed = switched || !same_size || diff_acc >= threshold;
      v.changed = changed;
      v.diff_count = diff_acc;
      v.switched = switched;
      v.oversize = oversize;
      verdict_q.push_back(v);
      // a changed frame swaps banks and becomes the reference
      if (changed) begin
        ref_sel = !ref_sel;
        have_ref = 1'b1;
        ref_w = w;
        ref_h = h;
        if (switched) prev_src = src;
      end
      diff_acc = '0;
      pos = 0;
    end
  endtask

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst) begin
      threshold = fcd_pkg::THRESHOLD_RESET;
      whole_screen = 1'b0;
      ref_sel = 1'b0;
      have_ref = 1'b0;
      ref_w = '0;
      ref_h = '0;
      prev_src = '0;
      diff_acc = '0;
      pos = 0;
      verdict_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.changed = m_tuser[0];
        got.diff_count = m_tdata[fcd_pkg::COUNT_W-1:0];
        got.switched = m_tuser[1];
        got.oversize = m_tuser[2];
        if (verdict_q.size() == 0) begin
          $error("result transfer with no frame outstanding: differing_pixels %0d",
                 got.diff_count);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          check_field("frame_changed", want.changed, got.changed);
          check_field("differing_pixels", want.diff_count, got.diff_count);
          check_field("source_switched", want.switched, got.switched);
          check_field("frame_too_large", want.oversize, got.oversize);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (fcd_pkg::cfg_reg_t'(cfg_index))
          fcd_pkg::REG_CHANGE_THRESHOLD: threshold = cfg_data;
          fcd_pkg::REG_WHOLE_SCREEN:     whole_screen = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) absorb_pixel(s_tdata, s_tuser, s_tlast);
    end
    verdicts_due <= verdict_q.size();
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the frame change detector: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DEPTH = fcd_pkg::MAX_PIXELS;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic [fcd_pkg::IN_TDATA_W-1:0]    s_tdata = '0;
  logic [fcd_pkg::SRC_W-1:0]         s_tuser = '0;
  logic                              s_tlast = 1'b0;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [fcd_pkg::OUT_TDATA_W-1:0]   m_tdata;
  logic [fcd_pkg::OUT_TUSER_W-1:0]   m_tuser;
  logic                              m_tvalid;
  logic                              m_tready = 1'b1;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [fcd_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [fcd_pkg::COUNT_W-1:0]       cfg_data = '0;
  int                                verdicts_due;
  int                                fail_count;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int unsigned cycle_count = 0;

  // Last frame sent, used to build frames that mostly repeat it
  bit [fcd_pkg::PIX_W-1:0] scene [0:DEPTH-1];

  // What the sender knows for sure about the reference: its size and source,
  // and lower bounds on how far each bank has been written since reset
  bit                        gen_have_ref = 1'b0;
  bit [fcd_pkg::SIDE_W-1:0]  gen_ref_w = '0;
  bit [fcd_pkg::SIDE_W-1:0]  gen_ref_h = '0;
  bit [fcd_pkg::SRC_W-1:0]   gen_src = '0;
  bit [fcd_pkg::COUNT_W-1:0] gen_thresh = fcd_pkg::THRESHOLD_RESET;
  bit                        gen_whole = 1'b0;
  int unsigned               ref_fill = 0;
  int unsigned               spare_fill = 0;

  frame_change_detector dut (.*);
  fcd_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_pixel(input logic [fcd_pkg::PIX_W-1:0] pix,
                            input logic [fcd_pkg::SRC_W-1:0] src,
                            input logic [fcd_pkg::SIDE_W-1:0] w,
                            input logic [fcd_pkg::SIDE_W-1:0] h, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= fcd_pkg::IN_TDATA_W'({h, w, pix});
    s_tuser <= src;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_regs(input logic [fcd_pkg::COUNT_W-1:0] thresh, input logic whole);
    cfg_valid <= 1'b1;
    cfg_index <= fcd_pkg::REG_CHANGE_THRESHOLD;
    cfg_data <= thresh;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= fcd_pkg::REG_WHOLE_SCREEN;
    cfg_data <= {16'($urandom), whole};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gen_thresh = thresh;
    gen_whole = whole;
  endtask

  // Hold the input until every verdict is out and the pipeline is empty
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (verdicts_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_frame(input int unsigned count, input logic [fcd_pkg::SIDE_W-1:0] w,
                            input logic [fcd_pkg::SIDE_W-1:0] h,
                            input logic [fcd_pkg::SRC_W-1:0] src,
                            input int edit_pct, input int size_noise_pct);
    logic [fcd_pkg::SIDE_W-1:0] pw;
    logic [fcd_pkg::SIDE_W-1:0] ph;
    logic [fcd_pkg::SRC_W-1:0]  psrc;
    logic [fcd_pkg::PIX_W-1:0]  pix;
    logic                       match;
    logic                       switched;
    int unsigned                compared;
    int unsigned                stored;
    int unsigned                grown;
    int unsigned                old_ref;
    compared = 0;
    match = 1'b0;
    pw = w;
    ph = h;
    for (int unsigned p = 0; p < count; p++) begin
      pw = w;
      ph = h;
      psrc = src;
      if (p + 1 < count && $urandom_range(99) < size_noise_pct) begin
        pw = fcd_pkg::SIDE_W'($urandom);
        ph = fcd_pkg::SIDE_W'($urandom);
        psrc = fcd_pkg::SRC_W'($urandom);
      end
      match = gen_have_ref && pw == gen_ref_w && ph == gen_ref_h;
      // never compare against a store entry that may not have been written yet
      if (match && p < DEPTH && p >= ref_fill) begin
        pw = gen_ref_w + 13'd1;
        match = 1'b0;
      end
      if (match && p < DEPTH) compared++;
      pix = (p < DEPTH) ? scene[p] : fcd_pkg::PIX_W'($urandom);
      if ($urandom_range(99) < edit_pct) begin
        if ($urandom_range(1) == 1) pix ^= 24'(1) << $urandom_range(23);
        else pix ^= 24'($urandom_range(1, 24'hFFFFFF));
      end
      if (p < DEPTH) scene[p] = pix;
      push_pixel(pix, psrc, pw, ph, p + 1 == count);
    end
    switched = !gen_whole && src != gen_src;
    stored = (count < DEPTH) ? count : DEPTH;
    grown = (spare_fill > stored) ? spare_fill : stored;
    if (!match || switched || gen_thresh == 0) begin
      // surely changed: banks swap
      old_ref = ref_fill;
      ref_fill = grown;
      spare_fill = old_ref;
      gen_have_ref = 1'b1;
      gen_ref_w = pw;
      gen_ref_h = ph;
      if (switched) gen_src = src;
    end else if (compared < gen_thresh) begin
      spare_fill = grown;
    end else begin
      // outcome open: assume the worse of both banks
      ref_fill = (ref_fill < grown) ? ref_fill : grown;
      spare_fill = ref_fill;
    end
  endtask

  task automatic random_frame(output int unsigned sent);
    logic [fcd_pkg::SIDE_W-1:0] w;
    logic [fcd_pkg::SIDE_W-1:0] h;
    logic [fcd_pkg::SRC_W-1:0]  src;
    int unsigned                area;
    int                         edit_pct;
    src = gen_src;
    if ($urandom_range(99) < 15) src = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
    case ($urandom_range(3))
      0: edit_pct = 0;
      1: edit_pct = 3;
      2: edit_pct = 15;
      default: edit_pct = 100;
    endcase
    if ($urandom_range(99) < 75) begin
      if (gen_have_ref && $urandom_range(99) < 65) begin
        w = gen_ref_w;
        h = gen_ref_h;
      end else begin
        w = fcd_pkg::SIDE_W'($urandom_range(1, 8));
        h = fcd_pkg::SIDE_W'($urandom_range(1, 8));
      end
      area = w * h;
      if (area == 0 || area > 64) area = $urandom_range(1, 16);
      // now and then a frame shorter or longer than its size says
      if ($urandom_range(9) == 0) area = $urandom_range(1, area + 4);
      if (gen_have_ref && w == gen_ref_w && h == gen_ref_h && ref_fill > 0 &&
          area > ref_fill && $urandom_range(9) != 0)
        area = ref_fill;
      send_frame(area, w, h, src, edit_pct, 0);
    end else begin
      area = $urandom_range(1, 20);
      send_frame(area, fcd_pkg::SIDE_W'($urandom), fcd_pkg::SIDE_W'($urandom),
                 16'($urandom), edit_pct, 30);
    end
    sent = area;
  endtask

  initial begin
    logic [fcd_pkg::COUNT_W-1:0] thresh;
    int unsigned                 sent;
    int unsigned                 n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed frames at reset settings
    scene[0] = 24'h000000;
    scene[1] = 24'hFFFFFF;
    scene[2] = 24'h555555;
    scene[3] = 24'hAAAAAA;
    send_frame(4, 2, 2, 16'h0000, 0, 0);
    send_frame(4, 2, 2, 16'h0000, 0, 0);
    send_frame(4, 2, 2, 16'hFFFF, 100, 0);
    send_frame(2, 2, 2, 16'hFFFF, 100, 0);
    send_frame(3, 13'd4096, 13'd4096, 16'hFFFF, 0, 0);
    send_frame(1, 13'h1FFF, 13'h1FFF, 16'h8000, 0, 0);
    send_frame(5, 13'h1FFF, 13'h1FFF, 16'h8000, 50, 60);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 58; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 58; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      for (int half = 0; half < 2; half++) begin
        drain();
        case ($urandom_range(5))
          0: thresh = '0;
          1: thresh = 17'd65536;
          2: thresh = '1;
          default: thresh = 17'($urandom_range(1, 8));
        endcase
        if (phase == 0 && half == 0) thresh = '0;
        write_regs(thresh, half == 1);
        sent = 0;
        while (sent < 106) begin
          random_frame(n);
          sent += n;
        end
      end
    end
    drain();

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
